// ===== rtl/psttrig_pkg.sv =====
// Package with the shared types and constants of the periodic slot task trigger.
`default_nettype none

package psttrig_pkg;

    // Default number of task slots.
    localparam int SLOTS_DEF = 8;

    // Field widths of the stream payloads.
    localparam int ACTION_W   = 2;
    localparam int TASK_ID_W  = 8;
    localparam int INTERVAL_W = 16;
    localparam int COUNT_W    = 16;
    localparam int MASK_W     = 8;

    // Byte-padded widths of the tdata buses.
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    // Item kinds carried on the input tuser.
    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 2'd0,
        ACT_ATTACH  = 2'd1,
        ACT_MESSAGE = 2'd2
    } t_action;

    // Control states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_HOLD
    } t_state;

    // One word of the slot memory.
    typedef struct packed {
        logic [TASK_ID_W-1:0]  task_id;
        logic [INTERVAL_W-1:0] interval;
        logic [COUNT_W-1:0]    count;
    } t_entry;

    // One result item.
    typedef struct packed {
        logic              attach_error;
        logic [MASK_W-1:0] mailbox_mask;
        logic [MASK_W-1:0] fired_mask;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/psttrig_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module psttrig_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/periodic_slot_task_trigger.sv =====
// Top level of the periodic slot task trigger: a tick-driven task slot scheduler.
`default_nettype none

// Channel  | Direction | Handshake                         | Payload
// ---------+-----------+-----------------------------------+------------------------------
// s_axis   | in        | i_s_axis_tvalid / o_s_axis_tready | tuser: action; tdata: kind,
//          |           |                                   | task id, interval
// m_axis   | out       | o_m_axis_tvalid / i_m_axis_tready | tdata: fired mask, mailbox
//          |           |                                   | mask, attach error
//
// An attach item, or an item with the unused action code, is finished in the cycle of
// its transfer. A tick or a message item is taken in the cycle of its transfer, then a
// sweep walks the slot memory one slot per cycle through its single read port, with
// each updated counter written back in the cycle after its read.
// Reset is synchronous and active low; it empties the table by clearing the per-slot
// flags, so no clearing pass is needed.
// A finished result sits in the output register; the next item is taken while it
// waits, and a second result is parked until the output transfer completes.

module periodic_slot_task_trigger #(
    parameter int SLOTS = psttrig_pkg::SLOTS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input stream.
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // tdata from bit 0 up: task_kind[0], task_id[8:1], interval[24:9], zero pad.
    input  wire logic [psttrig_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser from bit 0 up: action[1:0].
    input  wire logic [psttrig_pkg::ACTION_W-1:0]    i_s_axis_tuser,
    // Output stream.
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // tdata from bit 0 up: fired_mask[7:0], mailbox_mask[15:8], attach_error[16],
    // zero pad.
    output logic      [psttrig_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // Width of a slot index, and of a count that can hold SLOTS itself.
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    // Slots that appear in the 8-bit masks.
    localparam int NREP = (SLOTS < psttrig_pkg::MASK_W) ? SLOTS : psttrig_pkg::MASK_W;
    localparam int EW = $bits(psttrig_pkg::t_entry);

    // Unpacked input fields.
    psttrig_pkg::t_action                 in_action;
    logic                                 in_kind;
    logic [psttrig_pkg::TASK_ID_W-1:0]    in_id;
    logic [psttrig_pkg::INTERVAL_W-1:0]   in_ival;

    assign in_action = psttrig_pkg::t_action'(i_s_axis_tuser);
    assign in_kind   = i_s_axis_tdata[0];
    assign in_id     = i_s_axis_tdata[8:1];
    assign in_ival   = i_s_axis_tdata[24:9];

    // Per-slot flags live in flip-flops so that reset clears them at once.
    logic [SLOTS-1:0]  r_valid;
    logic [SLOTS-1:0]  r_one_shot;
    logic [SLOTS-1:0]  r_pending;
    logic [SLOTS-1:0]  r_mailbox;
    logic [CW-1:0]     r_next_free;

    // Sweep control.
    psttrig_pkg::t_state  r_state;
    psttrig_pkg::t_state  n_state;
    psttrig_pkg::t_action r_op;
    logic [psttrig_pkg::TASK_ID_W-1:0] r_id;
    logic [CW-1:0]        r_rd_cnt;
    logic                 r_proc_vld;
    logic [SW-1:0]        r_proc_addr;

    // Result storage.
    psttrig_pkg::t_result r_res;
    psttrig_pkg::t_result done_res;
    logic                 r_out_valid;
    psttrig_pkg::t_result r_out_data;

    // Memory ports.
    logic                 ram_we;
    logic [SW-1:0]        ram_waddr;
    psttrig_pkg::t_entry  ram_wdata;
    psttrig_pkg::t_entry  ram_rdata;
    logic [EW-1:0]        ram_rdata_raw;

    // Decoded control.
    logic in_xfer;
    logic out_free;
    logic sweep_done;
    logic res_done;
    logic load_out;
    logic park_res;
    logic start_sweep;
    logic can_attach;

    // Datapath of the slot under processing.
    logic [psttrig_pkg::COUNT_W:0] cnt_inc;
    logic [psttrig_pkg::COUNT_W-1:0] cnt_new;
    logic proc_periodic;
    logic proc_match;

    // Masks of a tick, taken from the flags when the tick is accepted.
    logic [psttrig_pkg::MASK_W-1:0] tick_fired;
    logic [psttrig_pkg::MASK_W-1:0] tick_mbox;

    psttrig_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS),
        .AW    (SW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_cnt[SW-1:0]),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = psttrig_pkg::t_entry'(ram_rdata_raw);

    assign in_xfer    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign sweep_done = (r_state == psttrig_pkg::ST_SWEEP) && r_proc_vld
                        && (r_rd_cnt == CW'(SLOTS));
    assign can_attach = (r_next_free < CW'(SLOTS));

    always_comb begin
        tick_fired = '0;
        tick_mbox  = '0;
        for (int b = 0; b < NREP; b++) begin
            tick_fired[b] = r_valid[b] && r_pending[b];
            tick_mbox[b]  = r_valid[b] && r_pending[b] && r_mailbox[b];
        end
    end

    // Counter update of the slot whose memory word has just come back.
    assign proc_periodic = r_valid[r_proc_addr] && !r_one_shot[r_proc_addr];
    assign proc_match    = r_valid[r_proc_addr] && (ram_rdata.task_id == r_id);
    assign cnt_inc = {1'b0, ram_rdata.count} + {{psttrig_pkg::COUNT_W{1'b0}}, 1'b1};
    assign cnt_new = (cnt_inc > {1'b0, ram_rdata.interval}) ? '0
                     : cnt_inc[psttrig_pkg::COUNT_W-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psttrig_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if ((in_action == psttrig_pkg::ACT_TICK)
                        || (in_action == psttrig_pkg::ACT_MESSAGE)) begin
                        n_state = psttrig_pkg::ST_SWEEP;
                    end else if (!out_free) begin
                        n_state = psttrig_pkg::ST_HOLD;
                    end
                end
            end
            psttrig_pkg::ST_SWEEP: begin
                if (sweep_done) begin
                    n_state = out_free ? psttrig_pkg::ST_IDLE : psttrig_pkg::ST_HOLD;
                end
            end
            psttrig_pkg::ST_HOLD: begin
                if (out_free) begin
                    n_state = psttrig_pkg::ST_IDLE;
                end
            end
            default: n_state = psttrig_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_s_axis_tready = 1'b0;
        start_sweep     = 1'b0;
        res_done        = 1'b0;
        done_res        = r_res;
        unique case (r_state)
            psttrig_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (in_xfer) begin
                    case (in_action) inside
                        psttrig_pkg::ACT_TICK, psttrig_pkg::ACT_MESSAGE: begin
                            start_sweep = 1'b1;
                        end
                        psttrig_pkg::ACT_ATTACH: begin
                            res_done = 1'b1;
                            done_res = '{attach_error: !can_attach,
                                         mailbox_mask: '0, fired_mask: '0};
                        end
                        default: begin
                            res_done = 1'b1;
                            done_res = '0;
                        end
                    endcase
                end
            end
            psttrig_pkg::ST_SWEEP: begin
                res_done = sweep_done;
            end
            psttrig_pkg::ST_HOLD: begin
                res_done = 1'b1;
            end
            default: ;
        endcase
    end

    assign load_out = res_done && out_free;
    assign park_res = res_done && !out_free;

    // Memory writes: an attach fills a fresh slot, a tick sweep writes back the
    // counter in the cycle after its read. Both never coexist, and the sweep writes
    // only the slot it read before, never the one it reads now.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_proc_addr;
        ram_wdata = '{task_id: ram_rdata.task_id, interval: ram_rdata.interval,
                      count: cnt_new};
        if (in_xfer && (in_action == psttrig_pkg::ACT_ATTACH)) begin
            ram_we    = can_attach;
            ram_waddr = r_next_free[SW-1:0];
            ram_wdata = '{task_id: in_id, interval: in_ival, count: '0};
        end else if ((r_state == psttrig_pkg::ST_SWEEP) && r_proc_vld
                     && (r_op == psttrig_pkg::ACT_TICK)) begin
            ram_we = proc_periodic;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psttrig_pkg::ST_IDLE;
            r_valid     <= '0;
            r_one_shot  <= '0;
            r_pending   <= '0;
            r_mailbox   <= '0;
            r_next_free <= '0;
            r_rd_cnt    <= '0;
            r_proc_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (in_xfer && (in_action == psttrig_pkg::ACT_ATTACH) && can_attach) begin
                r_valid[r_next_free[SW-1:0]]    <= 1'b1;
                r_one_shot[r_next_free[SW-1:0]] <= in_kind;
                r_pending[r_next_free[SW-1:0]]  <= 1'b0;
                r_mailbox[r_next_free[SW-1:0]]  <= 1'b0;
                r_next_free <= r_next_free + CW'(1);
            end

            // A tick fires every pending slot at once; the sweep then rearms.
            if (start_sweep && (in_action == psttrig_pkg::ACT_TICK)) begin
                r_pending <= '0;
                r_mailbox <= '0;
            end

            if (start_sweep) begin
                r_rd_cnt   <= '0;
                r_proc_vld <= 1'b0;
            end else if (r_state == psttrig_pkg::ST_SWEEP) begin
                if (r_rd_cnt < CW'(SLOTS)) begin
                    r_rd_cnt   <= r_rd_cnt + CW'(1);
                    r_proc_vld <= 1'b1;
                end else begin
                    r_proc_vld <= 1'b0;
                end
                if (r_proc_vld) begin
                    if (r_op == psttrig_pkg::ACT_TICK) begin
                        if (proc_periodic && (ram_rdata.count == '0)) begin
                            r_pending[r_proc_addr] <= 1'b1;
                        end
                    end else if (proc_match) begin
                        r_pending[r_proc_addr] <= 1'b1;
                        r_mailbox[r_proc_addr] <= 1'b1;
                    end
                end
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (start_sweep) begin
            r_op <= in_action;
            r_id <= in_id;
            if (in_action == psttrig_pkg::ACT_TICK) begin
                r_res <= '{attach_error: 1'b0, mailbox_mask: tick_mbox,
                           fired_mask: tick_fired};
            end else begin
                r_res <= '0;
            end
        end else if (park_res) begin
            r_res <= done_res;
        end
        if ((r_state == psttrig_pkg::ST_SWEEP) && (r_rd_cnt < CW'(SLOTS))) begin
            r_proc_addr <= r_rd_cnt[SW-1:0];
        end
        if (load_out) begin
            r_out_data <= done_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(psttrig_pkg::OUT_TDATA_W - $bits(psttrig_pkg::t_result)){1'b0}},
                              r_out_data};

`ifndef SYNTHESIS
    // A message sweep only reads the table.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == psttrig_pkg::ST_SWEEP) && (r_op == psttrig_pkg::ACT_MESSAGE))
        |-> !ram_we)
        else $error("slot memory written during a message sweep");

    // The fill pointer never passes the table size.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= CW'(SLOTS))
        else $error("next free slot beyond the table");

    // Only valid slots are pending, and a mailbox flag implies pending.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pending & ~r_valid) == '0) && ((r_mailbox & ~r_pending) == '0))
        else $error("slot flags out of step");

    // A parked result means the output register is occupied.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psttrig_pkg::ST_HOLD) |-> r_out_valid)
        else $error("result parked while the output is empty");

    // A started sweep has left the sweep state by the end of the checked delay.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_sweep |-> ##(SLOTS + 2) (r_state != psttrig_pkg::ST_SWEEP))
        else $error("sweep length wrong");
`endif

endmodule

`default_nettype wire

// ===== sim/periodic_slot_task_trigger_test.sv =====
// Self-checking stream testbench for the periodic slot task trigger.
`timescale 1ns / 1ps

module periodic_slot_task_trigger_test;

    import psttrig_pkg::*;

    localparam int SLOTS = SLOTS_DEF;

    // The package names only the three real item kinds; code 3 is unused.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // A tick or a message walks the table at one slot per cycle.
    localparam int ITEM_CYCLES  = SLOTS + 2;
    localparam int RANDOM_ITEMS = 1450;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 300;
    localparam int PAUSE_AT     = 700;
    // No transfer on either side for this many cycles ends the run.
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;

    // One row of the directed stimulus table.
    typedef struct {
        logic [ACTION_W-1:0]   action;
        logic                  kind;
        logic [TASK_ID_W-1:0]  id;
        logic [INTERVAL_W-1:0] ival;
        bit                    typed;
        t_result               want;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic [ACTION_W-1:0]    i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    // The testbench's own copy of the slot table.
    bit                    tbl_valid    [SLOTS];
    bit                    tbl_one_shot [SLOTS];
    logic [TASK_ID_W-1:0]  tbl_id       [SLOTS];
    logic [INTERVAL_W-1:0] tbl_interval [SLOTS];
    logic [COUNT_W-1:0]    tbl_count    [SLOTS];
    bit                    tbl_pending  [SLOTS];
    bit                    tbl_mailbox  [SLOTS];
    int                    tbl_next_free;

    // Results owed by the block, oldest first.
    t_result pending_results[$];
    t_row    directed_rows[$];

    int      error_count;
    int      idle_cycles;
    bit      quiet;       // no idling on either side while set
    bit      hold_req;    // asks the receiver for one long hold-off
    t_result got_result;
    t_result want_result;

    periodic_slot_task_trigger u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 12 ns clock period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Applies one item to the local slot table and returns the result it
    // produces. Slots are never freed, so next_free only grows.
    function automatic t_result step_slot_table(
        input logic [ACTION_W-1:0]   action,
        input logic                  kind,
        input logic [TASK_ID_W-1:0]  id,
        input logic [INTERVAL_W-1:0] ival
    );
        t_result     res;
        int unsigned cnt;
        res = '0;
        if (action == ACT_ATTACH) begin
            if (tbl_next_free < SLOTS) begin
                tbl_valid[tbl_next_free]    = 1'b1;
                tbl_one_shot[tbl_next_free] = kind;
                tbl_id[tbl_next_free]       = id;
                tbl_interval[tbl_next_free] = ival;
                tbl_count[tbl_next_free]    = '0;
                tbl_pending[tbl_next_free]  = 1'b0;
                tbl_mailbox[tbl_next_free]  = 1'b0;
                tbl_next_free++;
            end else begin
                res.attach_error = 1'b1;
            end
        end else if (action == ACT_MESSAGE) begin
            // Only valid slots can match, even when a stale id equals the target.
            for (int s = 0; s < SLOTS; s++) begin
                if (tbl_valid[s] && tbl_id[s] == id) begin
                    tbl_pending[s] = 1'b1;
                    tbl_mailbox[s] = 1'b1;
                end
            end
        end else if (action == ACT_TICK) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (tbl_valid[s]) begin
                    if (tbl_pending[s]) begin
                        if (s < MASK_W) begin
                            res.fired_mask[s]   = 1'b1;
                            res.mailbox_mask[s] = tbl_mailbox[s];
                        end
                        tbl_pending[s] = 1'b0;
                        tbl_mailbox[s] = 1'b0;
                    end
                    // Periodic slots arm themselves at count zero. The count is
                    // compared before truncation so an interval of all ones wraps.
                    if (!tbl_one_shot[s]) begin
                        cnt = 32'(tbl_count[s]);
                        if (cnt == 0) begin
                            tbl_pending[s] = 1'b1;
                        end
                        cnt = cnt + 1;
                        if (cnt > 32'(tbl_interval[s])) begin
                            cnt = 0;
                        end
                        tbl_count[s] = cnt[COUNT_W-1:0];
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic add_row(
        input logic [ACTION_W-1:0]   action,
        input logic                  kind,
        input logic [TASK_ID_W-1:0]  id,
        input logic [INTERVAL_W-1:0] ival,
        input bit                    typed,
        input t_result               want
    );
        t_row row;
        row.action = action;
        row.kind   = kind;
        row.id     = id;
        row.ival   = ival;
        row.typed  = typed;
        row.want   = want;
        directed_rows.push_back(row);
    endtask

    // Offers one item after a random gap and waits for its transfer. The
    // expected result is recorded at the edge where the transfer happens.
    task automatic send_item(
        input logic [ACTION_W-1:0]   action,
        input logic                  kind,
        input logic [TASK_ID_W-1:0]  id,
        input logic [INTERVAL_W-1:0] ival,
        input bit                    typed,
        input t_result               want
    );
        int      gap;
        t_result predicted;
        @(negedge i_clk);
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tdata  = {{(IN_TDATA_W - 25){1'b0}}, ival, id, kind};
        i_s_axis_tuser  = action;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = step_slot_table(action, kind, id, ival);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic report_mismatch(input string what, input t_result exp_r,
                                   input t_result act_r);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t: %s: expected fired=%02h mbox=%02h err=%0b, got fired=%02h mbox=%02h err=%0b",
                     $realtime, what, exp_r.fired_mask, exp_r.mailbox_mask,
                     exp_r.attach_error, act_r.fired_mask, act_r.mailbox_mask,
                     act_r.attach_error);
        end
    endtask

    // Result checker: every output transfer is compared with the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_result.fired_mask   = o_m_axis_tdata[7:0];
            got_result.mailbox_mask = o_m_axis_tdata[15:8];
            got_result.attach_error = o_m_axis_tdata[16];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, got_result);
            end else begin
                want_result = pending_results.pop_front();
                if (got_result.fired_mask !== want_result.fired_mask ||
                    got_result.mailbox_mask !== want_result.mailbox_mask ||
                    got_result.attach_error !== want_result.attach_error) begin
                    report_mismatch("result mismatch", want_result, got_result);
                end
            end
        end
    end

    // Watchdog: a long run of cycles without any transfer means the block hung.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: a random stall before each result, and one long hold-off on
    // request so that the block fills up and pushes back on its input.
    initial begin
        int gap;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            gap = quiet ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // Sender and run control.
    initial begin
        logic [ACTION_W-1:0]   action;
        logic                  kind;
        logic [TASK_ID_W-1:0]  id;
        logic [INTERVAL_W-1:0] ival;
        int                    pick;
        t_result               none;
        t_result               full;

        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = ACT_TICK;
        error_count     = 0;
        idle_cycles     = 0;
        quiet           = 1'b0;
        hold_req        = 1'b0;
        tbl_next_free   = 0;
        for (int s = 0; s < SLOTS; s++) begin
            tbl_valid[s]    = 1'b0;
            tbl_one_shot[s] = 1'b0;
            tbl_id[s]       = '0;
            tbl_interval[s] = '0;
            tbl_count[s]    = '0;
            tbl_pending[s]  = 1'b0;
            tbl_mailbox[s]  = 1'b0;
        end
        none = '0;
        full = '0;
        full.attach_error = 1'b1;

        // Directed part. Rows with a typed result are those whose answer is
        // plain: an empty table, an attach to a free or a full table, a
        // message (never fires by itself) and the unused action code.
        add_row(ACT_TICK,    1'b0, 8'h00, 16'h0000, 1'b1, none);  // empty table
        add_row(ACT_MESSAGE, 1'b0, 8'h00, 16'h0000, 1'b1, none);  // no valid slot
        add_row(ACT_UNUSED,  1'b0, 8'h00, 16'h0000, 1'b1, none);
        add_row(ACT_ATTACH,  1'b0, 8'h00, 16'h0000, 1'b1, none);  // fires every tick
        add_row(ACT_ATTACH,  1'b1, 8'hFF, 16'hFFFF, 1'b1, none);  // one-shot
        add_row(ACT_ATTACH,  1'b0, 8'hA5, 16'hFFFF, 1'b1, none);  // widest interval
        add_row(ACT_ATTACH,  1'b0, 8'h5A, 16'h0002, 1'b1, none);
        add_row(ACT_ATTACH,  1'b1, 8'hA5, 16'h0001, 1'b1, none);  // duplicate id
        add_row(ACT_TICK,    1'b0, 8'h00, 16'h0000, 1'b0, none);
        add_row(ACT_TICK,    1'b1, 8'hFF, 16'hFFFF, 1'b0, none);
        add_row(ACT_MESSAGE, 1'b0, 8'hA5, 16'h0000, 1'b1, none);  // two slots match
        add_row(ACT_MESSAGE, 1'b0, 8'h77, 16'h0000, 1'b1, none);  // unmatched id
        add_row(ACT_TICK,    1'b0, 8'h00, 16'h0000, 1'b0, none);
        add_row(ACT_ATTACH,  1'b0, 8'h01, 16'h0001, 1'b1, none);
        add_row(ACT_ATTACH,  1'b1, 8'h02, 16'h1234, 1'b1, none);
        add_row(ACT_ATTACH,  1'b0, 8'h03, 16'h0003, 1'b1, none);  // last free slot
        add_row(ACT_ATTACH,  1'b0, 8'h04, 16'h0005, 1'b1, full);  // table full
        add_row(ACT_ATTACH,  1'b0, 8'h09, 16'h0001, 1'b1, full);  // still full
        add_row(ACT_MESSAGE, 1'b0, 8'hFF, 16'h0000, 1'b1, none);
        add_row(ACT_MESSAGE, 1'b0, 8'h00, 16'h0000, 1'b1, none);
        add_row(ACT_TICK,    1'b0, 8'h00, 16'h0000, 1'b0, none);
        add_row(ACT_TICK,    1'b0, 8'h00, 16'h0000, 1'b0, none);
        add_row(ACT_UNUSED,  1'b1, 8'hFF, 16'hFFFF, 1'b1, none);
        add_row(ACT_TICK,    1'b0, 8'h00, 16'h0000, 1'b0, none);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].action, directed_rows[r].kind, directed_rows[r].id,
                      directed_rows[r].ival, directed_rows[r].typed, directed_rows[r].want);
        end

        // Random part. The table is full by now, so most items are ticks and
        // messages aimed at attached ids, with unmatched ids, failing attaches
        // and the unused code as noise. Ignored fields carry random bits too.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = ((n / 150) % 5 == 2);
            if (n == HOLD_AT) begin
                hold_req = 1'b1;
            end
            if (n == PAUSE_AT) begin
                @(negedge i_clk);
                i_s_axis_tvalid = 1'b0;
                while (pending_results.size() != 0) @(negedge i_clk);
            end
            kind = 1'($urandom_range(0, 1));
            id   = TASK_ID_W'($urandom_range(0, 255));
            ival = INTERVAL_W'($urandom_range(0, 65535));
            pick = $urandom_range(0, 99);
            if (pick < 48) begin
                action = ACT_TICK;
            end else if (pick < 78) begin
                action = ACT_MESSAGE;
                if (tbl_next_free > 0) begin
                    id = tbl_id[$urandom_range(0, tbl_next_free - 1)];
                end
            end else if (pick < 86) begin
                action = ACT_MESSAGE;
            end else if (pick < 94) begin
                action = ACT_ATTACH;
            end else begin
                action = ACT_UNUSED;
            end
            send_item(action, kind, id, ival, 1'b0, none);
        end

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;

        // Wait for every owed result, then a few item times for strays.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4 * ITEM_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/psttrig_pkg.sv
rtl/psttrig_ram.sv
rtl/periodic_slot_task_trigger.sv
sim/periodic_slot_task_trigger_test.sv
